// File: src/itda_pkg.sv
// ----------------------------------------------------------------------------
// itda_pkg
// Shared types and constants for the integer to decimal text converter.
// ----------------------------------------------------------------------------
package itda_pkg;

	localparam int unsigned NUM_DIGITS     = 10;
	localparam int unsigned VALUE_W        = 32;
	localparam int unsigned BITS_PER_STEP  = 4;
	localparam int unsigned CONV_STEPS     = VALUE_W / BITS_PER_STEP;
	localparam int unsigned STEP_W         = $clog2(CONV_STEPS);

	localparam logic [7:0] ASCII_ZERO  = 8'd48;
	localparam logic [7:0] ASCII_MINUS = 8'd45;

	typedef struct packed {
		logic load;
		logic step;
		logic emit;
	} itda_cmd_t;

	typedef struct packed {
		logic last;
	} itda_sts_t;

endpackage

// File: src/itda_datapath.sv
// ----------------------------------------------------------------------------
// itda_datapath
// Magnitude register, shift-and-add-3 BCD converter taking four bits a step,
// and the character selection for output.
// ----------------------------------------------------------------------------
module itda_datapath
	import itda_pkg::*;
(
	input  logic        clk,
	input  itda_cmd_t   cmd,
	output itda_sts_t   sts,
	input  logic [31:0] value,
	output logic [7:0]  character,
	output logic [3:0]  position,
	output logic [3:0]  text_length,
	output logic        last
);

	logic [VALUE_W-1:0]      mag_q;
	logic [4*NUM_DIGITS-1:0] bcd_q;
	logic                    neg_q;
	logic [3:0]              pos_q;

	logic [VALUE_W-1:0]      mag_in;
	logic [4*NUM_DIGITS-1:0] bcd_next;
	logic [3:0]              dig [NUM_DIGITS];
	logic [3:0]              ndig;
	logic [3:0]              len;
	logic [3:0]              dig_idx;

	assign mag_in = value[31] ? (32'd0 - value) : value;

	always_comb begin
		logic [4*NUM_DIGITS-1:0] b;
		b = bcd_q;
		for (int k = 0; k < BITS_PER_STEP; k++) begin
			for (int d = 0; d < NUM_DIGITS; d++) begin
				if (b[4*d +: 4] >= 4'd5)
					b[4*d +: 4] = b[4*d +: 4] + 4'd3;
			end
			b = {b[4*NUM_DIGITS-2:0], mag_q[VALUE_W-1-k]};
		end
		bcd_next = b;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= mag_in;
			neg_q <= value[31];
			bcd_q <= '0;
			pos_q <= '0;
		end else if (cmd.step) begin
			mag_q <= {mag_q[VALUE_W-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
			bcd_q <= bcd_next;
		end else if (cmd.emit) begin
			pos_q <= pos_q + 4'd1;
		end
	end

	always_comb begin
		ndig = 4'd1;
		for (int d = 0; d < NUM_DIGITS; d++) begin
			dig[d] = bcd_q[4*d +: 4];
			if (bcd_q[4*d +: 4] != 4'd0)
				ndig = 4'(d + 1);
		end
	end

	assign len     = ndig + {3'd0, neg_q};
	assign dig_idx = len - 4'd1 - pos_q;

	always_comb begin
		if (neg_q && pos_q == 4'd0)
			character = ASCII_MINUS;
		else if (dig_idx < 4'(NUM_DIGITS))
			character = ASCII_ZERO + {4'd0, dig[dig_idx]};
		else
			character = ASCII_ZERO;
	end

	assign position    = pos_q;
	assign text_length = len;
	assign last        = (pos_q + 4'd1) == len;
	assign sts.last    = last;

endmodule

// File: src/itda_ctrl.sv
// ----------------------------------------------------------------------------
// itda_ctrl
// Sequencer: accept a request, run the conversion steps, then hand out one
// character per output handshake.
// ----------------------------------------------------------------------------
module itda_ctrl
	import itda_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  itda_sts_t sts,
	output itda_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	state_t              state_q;
	logic [STEP_W-1:0]   step_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign cmd.load  = in_valid && in_ready;
	assign cmd.step  = (state_q == ST_CONV);
	assign cmd.emit  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (cmd.load)
						state_q <= ST_CONV;
				end
				ST_CONV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(CONV_STEPS - 1))
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (cmd.emit && sts.last)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: src/int_to_decimal_ascii.sv
// Sequence: a handshake takes the request, then the conversion steps shift all 32 bits
// (4 bits per cycle) through the BCD shifter, then one character per cycle while out_ready holds.
// A new request is taken only in idle, after the last character of the previous text
// has left; the conversion shifter and the one-character output port set the pace.
// Reset: arst_n clears the sequencer to idle; payload registers are not reset.
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// Signed 32-bit integer to decimal ASCII characters, sign first, no leading
// zeros, one character per result.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii
	import itda_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  character,
	output logic [3:0]  position,
	output logic [3:0]  text_length,
	output logic        last
);

	itda_cmd_t cmd;
	itda_sts_t sts;

	itda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	itda_datapath u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.sts         (sts),
		.value       (value),
		.character   (character),
		.position    (position),
		.text_length (text_length),
		.last        (last)
	);

endmodule

// File: src/itda_checker.sv
// ----------------------------------------------------------------------------
// itda_checker
// Port-level checks on the converter's request and character sequence.
// ----------------------------------------------------------------------------
module itda_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  character,
	input logic [3:0]  position,
	input logic [3:0]  text_length,
	input logic        last
);

	// hold a stalled character
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(character)
			&& $stable(position) && $stable(text_length))
		else $error("stalled character changed");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !out_valid)
		else $error("request taken while characters pending");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid
			&& position == $past(position) + 4'd1
			&& text_length == $past(text_length))
		else $error("character sequence broken");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> position < text_length
			&& last == (position + 4'd1 == text_length))
		else $error("position or last flag inconsistent");

endmodule

bind int_to_decimal_ascii itda_checker u_itda_checker (.*);

// File: verif/int_to_decimal_ascii_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_tb
// Sends signed 32-bit values to the converter and checks every character it
// returns (code, position, text length, last flag) against texts predicted
// inside the bench. Covers corner values, random words, every text length,
// random idling on both sides, a long output stall and drained pauses.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii_tb;
	import itda_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic [7:0] character;
		logic [3:0] position;
		logic [3:0] text_length;
		logic       last;
	} text_char_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] value;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  character;
	logic [3:0]  position;
	logic [3:0]  text_length;
	logic        last;

	text_char_t  pending_chars [$];
	int          errors;
	int          values_sent;
	int          chars_checked;
	int          cycles;
	logic [11:0] lengths_seen;
	bit          tx_idle;
	bit          rx_idle;
	int          rx_hold;

	int_to_decimal_ascii u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.character  (character),
		.position   (position),
		.text_length(text_length),
		.last       (last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void push_char(logic [7:0] ch, int pos, int len);
		text_char_t c;
		c.character   = ch;
		c.position    = 4'(pos);
		c.text_length = 4'(len);
		c.last        = (pos + 1 == len);
		pending_chars.push_back(c);
	endfunction

	function automatic void predict_text(logic [31:0] v);
		logic [31:0] mag;
		logic [3:0]  digits [10];
		int          ndig;
		int          len;
		int          pos;
		mag = v[31] ? (32'd0 - v) : v;
		ndig = 0;
		do begin
			digits[ndig] = 4'(mag % 32'd10);
			mag = mag / 32'd10;
			ndig++;
		end while (mag != 32'd0);
		len = ndig + int'(v[31]);
		pos = 0;
		if (v[31]) begin
			push_char(ASCII_MINUS, pos, len);
			pos++;
		end
		for (int i = ndig - 1; i >= 0; i--) begin
			push_char(ASCII_ZERO + 8'(digits[i]), pos, len);
			pos++;
		end
		lengths_seen[len] = 1'b1;
	endfunction

	function automatic logic [31:0] value_of_length(int unsigned nd, bit neg);
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mag;
		lo = 1;
		repeat (nd - 1) lo = lo * 10;
		hi = lo * 10 - 1;
		if (nd == 1)
			lo = 0;
		if (neg && hi > 64'd2147483648)
			hi = 64'd2147483648;
		if (!neg && hi > 64'd2147483647)
			hi = 64'd2147483647;
		mag = lo + ({$urandom, $urandom} % (hi - lo + 1));
		return neg ? (32'd0 - mag[31:0]) : mag[31:0];
	endfunction

	task automatic send_value(input logic [31:0] v);
		int gap;
		gap = tx_idle ? $urandom_range(0, 13) : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (!in_ready);
		predict_text(v);
		values_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_corner_values();
		logic [31:0] corners [$] = {
			32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99,
			32'd100, 32'd123456789, 32'd999999999, 32'd1000000000,
			-32'sd1000000000, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000
		};
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		foreach (corners[i])
			send_value(corners[i]);
		wait_idle();
	endtask

	task automatic test_random_words();
		for (int i = 0; i < 160; i++) begin
			if (i % 40 == 0) begin
				tx_idle = $urandom_range(0, 1);
				rx_idle = $urandom_range(0, 1);
			end
			send_value($urandom);
		end
		wait_idle();
	endtask

	task automatic test_every_length();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		for (int i = 0; i < 160; i++)
			send_value(value_of_length($urandom_range(1, 10), $urandom_range(0, 1)));
		wait_idle();
	endtask

	task automatic test_output_backpressure();
		tx_idle = 1'b0;
		rx_idle = 1'b1;
		rx_hold = 300;
		for (int i = 0; i < 30; i++)
			send_value(value_of_length($urandom_range(1, 10), $urandom_range(0, 1)));
		wait_idle();
	endtask

	task automatic test_drained_bursts();
		for (int b = 0; b < 5; b++) begin
			tx_idle = $urandom_range(0, 1);
			rx_idle = $urandom_range(0, 1);
			for (int i = 0; i < 8; i++)
				send_value(b[0] ? $urandom : value_of_length($urandom_range(1, 10),
					$urandom_range(0, 1)));
			wait_idle();
		end
	endtask

	// receiver: random stall before each character while rx_idle is set, or hold for a long stretch on request
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = rx_idle ? $urandom_range(0, 13) : 0;
			if (rx_hold > 0) begin
				stall   = rx_hold;
				rx_hold = 0;
			end
			repeat (stall) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_chars.size() == 0) begin
				$error("unexpected character %0d at position %0d", character, position);
				errors++;
			end else begin
				text_char_t exp_c;
				exp_c = pending_chars.pop_front();
				if (character !== exp_c.character) begin
					$error("character: expected %0d, got %0d", exp_c.character, character);
					errors++;
				end
				if (position !== exp_c.position) begin
					$error("position: expected %0d, got %0d", exp_c.position, position);
					errors++;
				end
				if (text_length !== exp_c.text_length) begin
					$error("text_length: expected %0d, got %0d", exp_c.text_length,
						text_length);
					errors++;
				end
				if (last !== exp_c.last) begin
					$error("last: expected %0d, got %0d", exp_c.last, last);
					errors++;
				end
				chars_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d characters outstanding", cycles,
				pending_chars.size());
			$display("int_to_decimal_ascii_tb NOT OK");
			$finish;
		end
	end

	initial begin
		errors        = 0;
		values_sent   = 0;
		chars_checked = 0;
		cycles        = 0;
		lengths_seen  = '0;
		tx_idle       = 1'b0;
		rx_idle       = 1'b0;
		rx_hold       = 0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		value         = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_corner_values();
		test_random_words();
		test_every_length();
		test_output_backpressure();
		test_drained_bursts();

		if (pending_chars.size() != 0) begin
			$error("%0d characters never arrived", pending_chars.size());
			errors++;
		end
		$display("converted %0d values into %0d checked characters, %0d text lengths seen",
			values_sent, chars_checked, $countones(lengths_seen));
		$display("random idling, a 300-cycle output stall and drained pauses included");
		if (errors == 0)
			$display("int_to_decimal_ascii_tb OK");
		else
			$display("int_to_decimal_ascii_tb NOT OK");
		$finish;
	end

endmodule
